>>> hdl/i2ct_pkg.sv
// Shared constants, codes and types for the I2C target register file and EEPROM back end.
// Used by the configuration interface and every module of the block except i2ct_ram; depends on nothing.
package i2ct_pkg;

  localparam int NUM_PAGES    = 4;
  localparam int PAGE_BYTES   = 256;
  localparam int EEPROM_BYTES = 8192;
  localparam int HEADER_BYTES = 64;

  localparam int PageSlots  = 4;
  localparam int PagesCap   = (NUM_PAGES < PageSlots) ? NUM_PAGES : PageSlots;
  localparam int PgAw       = $clog2(NUM_PAGES * PAGE_BYTES);
  localparam int EepAw      = $clog2(EEPROM_BYTES);
  localparam int HdrAw      = $clog2(HEADER_BYTES);
  localparam int OpAw0      = (PgAw > EepAw) ? PgAw : EepAw;
  localparam int OpAw       = (OpAw0 > HdrAw) ? OpAw0 : HdrAw;
  localparam int CfgDataW   = 36;
  localparam int QueueDepth = 2;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);
  localparam int QueuePtrW  = $clog2(QueueDepth);

  localparam logic [7:0] CmdReg   = 8'hFD;
  localparam logic [7:0] HighMask = 8'h1F;
  localparam logic [7:0] NoPageId = 8'hFF;
  localparam logic [7:0] ZeroByte = 8'h00;

  typedef enum logic [2:0] {
    FN_START_PRI,
    FN_START_SEC,
    FN_RECEIVE,
    FN_TRANSMIT,
    FN_STOP,
    FN_HOST_WR,
    FN_HOST_RD
  } func_e;

  typedef enum logic [1:0] {
    TGT_HEADER,
    TGT_EEPROM,
    TGT_PAGE
  } host_tgt_e;

  typedef enum logic [1:0] {
    CFG_PAGE_COUNT,
    CFG_PAGE_IDS,
    CFG_PAGE_SIZES,
    CFG_EEPROM_SIZE
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_NONE,
    ST_HEADER,
    ST_EEPROM,
    ST_PAGE
  } store_e;

  typedef struct packed {
    store_e            sel;
    logic              we;
    logic [OpAw-1:0]   addr;
    logic [7:0]        wdata;
    logic [7:0]        imm;
    logic              stored;
    logic              page_sel;
  } op_t;

  function automatic logic [PgAw-1:0] page_addr(input logic [1:0] idx, input logic [7:0] off);
    return PgAw'(idx) * PgAw'(PAGE_BYTES) + PgAw'(off);
  endfunction

endpackage

>>> hdl/i2ct_item_if.sv
// Input channel carrying one bus or host event word.
// Plain valid/ready handshake; no dependencies.
interface i2ct_item_if ();
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [7:0]  data;
  logic [1:0]  host_target;
  logic [1:0]  host_page;
  logic [12:0] host_addr;

  modport source (output valid, func, data, host_target, host_page, host_addr, input ready);
  modport sink   (input valid, func, data, host_target, host_page, host_addr, output ready);
endinterface

>>> hdl/i2ct_res_if.sv
// Output channel carrying one result word per event.
// Plain valid/ready handshake; no dependencies.
interface i2ct_res_if ();
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       byte_stored;
  logic       page_selected;

  modport source (output valid, read_data, byte_stored, page_selected, input ready);
  modport sink   (input valid, read_data, byte_stored, page_selected, output ready);
endinterface

>>> hdl/i2ct_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on i2ct_pkg for the data width.
interface i2ct_cfg_if import i2ct_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/i2ct_ram.sv
// Generic single-port RAM with registered read data.
// Stand-alone; used for the header, EEPROM and page stores.
module i2ct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/i2ct_front.sv
// Front end: holds configuration and protocol state, classifies each event word and
// emits one store operation per word. Depends on i2ct_pkg and the channel interfaces.
module i2ct_front import i2ct_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  i2ct_item_if.sink item_i,
  i2ct_cfg_if.sink  cfg_i,
  output op_t    op_o,
  output logic   op_valid_o,
  input  logic   op_ready_i
);

  logic [2:0]  page_count_q;
  logic [31:0] page_ids_q;
  logic [35:0] page_sizes_q;
  logic [13:0] eeprom_size_q;

  logic        sec_q, sec_d;
  logic        pv_q, pv_d;
  logic [1:0]  pidx_q, pidx_d;
  logic [7:0]  ptr_q, ptr_d;
  logic        ptr_set_q, ptr_set_d;
  logic [15:0] eptr_q, eptr_d;
  logic        hi_q, hi_d;
  logic        lo_q, lo_d;

  logic        accept;
  logic [2:0]  pages_used;
  logic [8:0]  psize_raw;
  logic [8:0]  psize;
  logic [13:0] eep_lim;
  logic        access_ok;
  logic        eep_in_range;
  logic        found;
  logic [1:0]  hit_idx;
  store_e      host_sel;
  logic [OpAw-1:0] host_addr_m;
  op_t         op;

  assign accept     = item_i.valid && op_ready_i;
  assign item_i.ready = op_ready_i;
  assign cfg_i.ready  = 1'b1;

  assign pages_used   = (32'(page_count_q) > PagesCap) ? 3'(PagesCap) : page_count_q;
  assign psize_raw    = page_sizes_q[9*pidx_q +: 9];
  assign psize        = (32'(psize_raw) > PAGE_BYTES) ? 9'(PAGE_BYTES) : psize_raw;
  assign eep_lim      = (32'(eeprom_size_q) > EEPROM_BYTES) ? 14'(EEPROM_BYTES) : eeprom_size_q;
  assign access_ok    = pv_q && (32'(pidx_q) < NUM_PAGES) && ({1'b0, ptr_q} < psize);
  assign eep_in_range = eptr_q < {2'b00, eep_lim};

  always_comb begin
    found   = 1'b0;
    hit_idx = pidx_q;
    for (int i = 0; i < PageSlots; i++) begin
      if ((i < 32'(pages_used)) && (page_ids_q[8*i +: 8] == item_i.data)) begin
        found   = 1'b1;
        hit_idx = 2'(i);
      end
    end
  end

  always_comb begin
    host_sel    = ST_NONE;
    host_addr_m = '0;
    case (item_i.host_target)
      TGT_HEADER: begin
        if (32'(item_i.host_addr) < HEADER_BYTES) begin
          host_sel    = ST_HEADER;
          host_addr_m = OpAw'(item_i.host_addr[HdrAw-1:0]);
        end
      end
      TGT_EEPROM: begin
        if (32'(item_i.host_addr) < EEPROM_BYTES) begin
          host_sel    = ST_EEPROM;
          host_addr_m = OpAw'(item_i.host_addr[EepAw-1:0]);
        end
      end
      TGT_PAGE: begin
        if ((32'(item_i.host_page) < NUM_PAGES) && (32'(item_i.host_addr) < PAGE_BYTES)) begin
          host_sel    = ST_PAGE;
          host_addr_m = OpAw'(page_addr(item_i.host_page, item_i.host_addr[7:0]));
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    sec_d     = sec_q;
    pv_d      = pv_q;
    pidx_d    = pidx_q;
    ptr_d     = ptr_q;
    ptr_set_d = ptr_set_q;
    eptr_d    = eptr_q;
    hi_d      = hi_q;
    lo_d      = lo_q;
    op        = '0;
    op.sel    = ST_NONE;
    op.wdata  = item_i.data;
    op.imm    = ZeroByte;
    case (item_i.func)
      FN_START_PRI: begin
        sec_d     = 1'b0;
        ptr_set_d = 1'b0;
      end
      FN_START_SEC: begin
        sec_d = 1'b1;
        if (hi_q && !lo_q) begin
          eptr_d = eptr_q | {8'h00, item_i.data};
          lo_d   = 1'b1;
        end else begin
          hi_d = 1'b0;
          lo_d = 1'b0;
        end
      end
      FN_RECEIVE: begin
        if (sec_q) begin
          if (!hi_q) begin
            eptr_d = {3'b000, item_i.data[4:0] & HighMask[4:0], 8'h00};
            hi_d   = 1'b1;
          end else if (!lo_q) begin
            eptr_d = eptr_q | {8'h00, item_i.data};
            lo_d   = 1'b1;
          end else begin
            if (eep_in_range) begin
              op.sel    = ST_EEPROM;
              op.we     = 1'b1;
              op.addr   = OpAw'(eptr_q[EepAw-1:0]);
              op.stored = 1'b1;
            end
            eptr_d = eptr_q + 16'd1;
          end
        end else if (!ptr_set_q) begin
          ptr_d     = item_i.data;
          ptr_set_d = 1'b1;
        end else if (ptr_q == CmdReg) begin
          pv_d = found;
          if (found) begin
            pidx_d = hit_idx;
            ptr_d  = 8'h00;
          end
        end else if (access_ok) begin
          op.sel    = ST_PAGE;
          op.we     = 1'b1;
          op.addr   = OpAw'(page_addr(pidx_q, ptr_q));
          op.stored = 1'b1;
          ptr_d     = ptr_q + 8'd1;
        end
      end
      FN_TRANSMIT: begin
        if (sec_q) begin
          if (eep_in_range) begin
            if (32'(eptr_q) < HEADER_BYTES) begin
              op.sel  = ST_HEADER;
              op.addr = OpAw'(eptr_q[HdrAw-1:0]);
            end else begin
              op.sel  = ST_EEPROM;
              op.addr = OpAw'(eptr_q[EepAw-1:0]);
            end
          end
          eptr_d = eptr_q + 16'd1;
        end else if (ptr_q == CmdReg) begin
          op.imm = pv_q ? page_ids_q[8*pidx_q +: 8] : NoPageId;
        end else if (access_ok) begin
          op.sel  = ST_PAGE;
          op.addr = OpAw'(page_addr(pidx_q, ptr_q));
          ptr_d   = ptr_q + 8'd1;
        end
      end
      FN_HOST_WR: begin
        op.sel  = host_sel;
        op.addr = host_addr_m;
        op.we   = 1'b1;
      end
      FN_HOST_RD: begin
        op.sel  = host_sel;
        op.addr = host_addr_m;
      end
      default: ;
    endcase
    op.page_sel = pv_d;
  end

  assign op_o       = op;
  assign op_valid_o = item_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_count_q  <= '0;
      page_ids_q    <= '0;
      page_sizes_q  <= '0;
      eeprom_size_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_PAGE_COUNT:  page_count_q  <= cfg_i.data[2:0];
        CFG_PAGE_IDS:    page_ids_q    <= cfg_i.data[31:0];
        CFG_PAGE_SIZES:  page_sizes_q  <= cfg_i.data[35:0];
        CFG_EEPROM_SIZE: eeprom_size_q <= cfg_i.data[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q     <= 1'b0;
      pv_q      <= 1'b0;
      pidx_q    <= '0;
      ptr_q     <= '0;
      ptr_set_q <= 1'b0;
      eptr_q    <= '0;
      hi_q      <= 1'b0;
      lo_q      <= 1'b0;
    end else if (accept) begin
      sec_q     <= sec_d;
      pv_q      <= pv_d;
      pidx_q    <= pidx_d;
      ptr_q     <= ptr_d;
      ptr_set_q <= ptr_set_d;
      eptr_q    <= eptr_d;
      hi_q      <= hi_d;
      lo_q      <= lo_d;
    end
  end

endmodule

>>> hdl/i2ct_queue.sv
// Two-entry operation queue between the front and back ends.
// Depends on i2ct_pkg for the operation type and depth.
module i2ct_queue import i2ct_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  op_t  push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output op_t  pop_data_o
);

  op_t                  slot_q [QueueDepth];
  logic [QueueCntW-1:0] count_q, count_d;
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic                 push, pop;

  assign push_ready_o = (32'(count_q) < QueueDepth);
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + QueueCntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      wr_q    <= '0;
      rd_q    <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_q <= (32'(wr_q) == QueueDepth - 1) ? '0 : wr_q + QueuePtrW'(1);
      end
      if (pop) begin
        rd_q <= (32'(rd_q) == QueueDepth - 1) ? '0 : rd_q + QueuePtrW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= QueueDepth)
    else $error("queue fill count exceeds its depth");

endmodule

>>> hdl/i2ct_back.sv
// Back end: carries out store operations on the three RAMs and registers each result word.
// Depends on i2ct_pkg, i2ct_ram and the result channel interface.
module i2ct_back import i2ct_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  op_t  op_i,
  input  logic op_valid_i,
  output logic op_ready_o,
  i2ct_res_if.source result_o
);

  logic       pop;
  logic       s1_adv;
  logic       s1_vld_q;
  op_t        s1_op_q;
  logic       out_vld_q;
  logic [7:0] out_data_q;
  logic       out_stored_q;
  logic       out_psel_q;
  logic       hdr_en, eep_en, pg_en;
  logic [7:0] hdr_rdata, eep_rdata, pg_rdata;
  logic [7:0] res_data;

  assign s1_adv     = s1_vld_q && (!out_vld_q || result_o.ready);
  assign op_ready_o = !s1_vld_q || s1_adv;
  assign pop        = op_valid_i && op_ready_o;

  assign hdr_en = pop && (op_i.sel == ST_HEADER);
  assign eep_en = pop && (op_i.sel == ST_EEPROM);
  assign pg_en  = pop && (op_i.sel == ST_PAGE);

  i2ct_ram #(.WIDTH(8), .DEPTH(HEADER_BYTES)) u_hdr_ram (
    .clk_i   (clk_i),
    .en_i    (hdr_en),
    .we_i    (op_i.we),
    .addr_i  (op_i.addr[HdrAw-1:0]),
    .wdata_i (op_i.wdata),
    .rdata_o (hdr_rdata)
  );

  i2ct_ram #(.WIDTH(8), .DEPTH(EEPROM_BYTES)) u_eep_ram (
    .clk_i   (clk_i),
    .en_i    (eep_en),
    .we_i    (op_i.we),
    .addr_i  (op_i.addr[EepAw-1:0]),
    .wdata_i (op_i.wdata),
    .rdata_o (eep_rdata)
  );

  i2ct_ram #(.WIDTH(8), .DEPTH(NUM_PAGES * PAGE_BYTES)) u_pg_ram (
    .clk_i   (clk_i),
    .en_i    (pg_en),
    .we_i    (op_i.we),
    .addr_i  (op_i.addr[PgAw-1:0]),
    .wdata_i (op_i.wdata),
    .rdata_o (pg_rdata)
  );

  always_comb begin
    res_data = s1_op_q.imm;
    if (!s1_op_q.we) begin
      case (s1_op_q.sel)
        ST_HEADER: res_data = hdr_rdata;
        ST_EEPROM: res_data = eep_rdata;
        ST_PAGE:   res_data = pg_rdata;
        default:   res_data = s1_op_q.imm;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_op_q <= op_i;
    end
    if (s1_adv) begin
      out_data_q   <= res_data;
      out_stored_q <= s1_op_q.stored;
      out_psel_q   <= s1_op_q.page_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (pop) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign result_o.valid         = out_vld_q;
  assign result_o.read_data     = out_data_q;
  assign result_o.byte_stored   = out_stored_q;
  assign result_o.page_selected = out_psel_q;

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && out_vld_q && !result_o.ready) |=> (s1_vld_q && $stable(s1_op_q)))
    else $error("pending store access lost while the output word stalls");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_vld_q)
    else $error("advanced word did not reach the output register");

endmodule

>>> hdl/i2c_target_paged_regs_and_eeprom.sv
// Top level of the I2C target byte back end: paged register file and EEPROM emulation.
// Depends on i2ct_pkg, the channel interfaces, i2ct_front, i2ct_queue and i2ct_back.
//
// Channel   Direction  Word
// item_i    in         func, data, host_target, host_page, host_addr
// result_o  out        read_data, byte_stored, page_selected
// cfg_i     in         index, data (page_count, page_ids, page_sizes, eeprom_size)
//
// One event word is accepted per cycle while the queue is not full; its result word passes
// through the queue register, the registered RAM read and the output register, in that order.
// Reset is asynchronous and clears protocol state and configuration; stores are not cleared.
// A stalled result backs up into the queue, and item_i.ready drops once the queue is full.
module i2c_target_paged_regs_and_eeprom import i2ct_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  i2ct_item_if.sink   item_i,
  i2ct_res_if.source  result_o,
  i2ct_cfg_if.sink    cfg_i
);

  op_t  f_op;
  logic f_valid;
  logic f_ready;
  op_t  b_op;
  logic b_valid;
  logic b_ready;

  i2ct_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cfg_i      (cfg_i),
    .op_o       (f_op),
    .op_valid_o (f_valid),
    .op_ready_i (f_ready)
  );

  i2ct_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_op),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_op)
  );

  i2ct_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (b_op),
    .op_valid_i (b_valid),
    .op_ready_o (b_ready),
    .result_o   (result_o)
  );

endmodule

>>> tb/sv/i2ct_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for the I2C target back end: watches the event, result and configuration channels,
// predicts each result word from its own copy of the protocol state and stores, and compares.
// Depends on i2ct_pkg and the three channel interfaces.
module i2ct_scoreboard import i2ct_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  i2ct_item_if item_i,
  i2ct_res_if  result_i,
  i2ct_cfg_if  cfg_i,
  output int   mismatch_count_o,
  output int   pending_count_o
);

  localparam int IdSlots    = 4;
  localparam int MaxReports = 40;

  typedef struct packed {
    logic [7:0] read_data;
    logic       byte_stored;
    logic       page_selected;
  } result_word_t;

  logic [2:0]  page_count_q;
  logic [31:0] page_ids_q;
  logic [35:0] page_sizes_q;
  logic [13:0] eeprom_size_q;

  logic        on_secondary_q;
  logic        page_valid_q;
  logic [1:0]  page_index_q;
  logic [7:0]  reg_pointer_q;
  logic        pointer_set_q;
  logic [15:0] eeprom_pointer_q;
  logic        high_seen_q;
  logic        low_seen_q;

  logic [7:0] page_mem   [NUM_PAGES*PAGE_BYTES];
  logic [7:0] eeprom_mem [EEPROM_BYTES];
  logic [7:0] header_mem [HEADER_BYTES];

  result_word_t expected_words[$];
  int           mismatches = 0;

  function automatic logic [7:0] page_id(input int i);
    return page_ids_q[8*(i % IdSlots) +: 8];
  endfunction

  function automatic int eeprom_limit();
    return (int'(eeprom_size_q) > EEPROM_BYTES) ? EEPROM_BYTES : int'(eeprom_size_q);
  endfunction

  function automatic bit page_access_ok();
    int page_len;
    page_len = int'(page_sizes_q[9*page_index_q +: 9]);
    if (page_len > PAGE_BYTES) page_len = PAGE_BYTES;
    return page_valid_q && (int'(page_index_q) < NUM_PAGES) &&
           (int'(reg_pointer_q) < page_len);
  endfunction

  function automatic int page_slot();
    return int'(page_index_q) * PAGE_BYTES + int'(reg_pointer_q);
  endfunction

  function automatic result_word_t predict_word(input logic [2:0] fn, input logic [7:0] d,
                                                input logic [1:0] tgt, input logic [1:0] pg,
                                                input logic [12:0] addr);
    result_word_t w;
    int           used;
    int           a;
    bit           found;
    bit           wr;
    w = '0;
    case (fn)
      FN_START_PRI: begin
        on_secondary_q = 1'b0;
        pointer_set_q  = 1'b0;
      end
      FN_START_SEC: begin
        on_secondary_q = 1'b1;
        if (high_seen_q && !low_seen_q) begin
          eeprom_pointer_q = eeprom_pointer_q | {8'h00, d};
          low_seen_q       = 1'b1;
        end else begin
          high_seen_q = 1'b0;
          low_seen_q  = 1'b0;
        end
      end
      FN_RECEIVE: begin
        if (on_secondary_q) begin
          if (!high_seen_q) begin
            eeprom_pointer_q = {d & HighMask, 8'h00};
            high_seen_q      = 1'b1;
          end else if (!low_seen_q) begin
            eeprom_pointer_q = eeprom_pointer_q | {8'h00, d};
            low_seen_q       = 1'b1;
          end else begin
            if (int'(eeprom_pointer_q) < eeprom_limit()) begin
              eeprom_mem[eeprom_pointer_q[12:0]] = d;
              w.byte_stored = 1'b1;
            end
            eeprom_pointer_q = eeprom_pointer_q + 16'd1;
          end
        end else if (!pointer_set_q) begin
          reg_pointer_q = d;
          pointer_set_q = 1'b1;
        end else if (reg_pointer_q == CmdReg) begin
          found = 1'b0;
          used  = int'(page_count_q);
          if (used > NUM_PAGES) used = NUM_PAGES;
          if (used > IdSlots) used = IdSlots;
          for (int i = 0; i < used; i++) begin
            if (page_id(i) == d) begin
              page_index_q  = 2'(i);
              reg_pointer_q = 8'h00;
              found         = 1'b1;
            end
          end
          page_valid_q = found;
        end else if (page_access_ok()) begin
          page_mem[page_slot()] = d;
          w.byte_stored = 1'b1;
          reg_pointer_q = reg_pointer_q + 8'd1;
        end
      end
      FN_TRANSMIT: begin
        if (on_secondary_q) begin
          a = int'(eeprom_pointer_q);
          if (a < eeprom_limit()) begin
            w.read_data = (a < HEADER_BYTES) ? header_mem[a] : eeprom_mem[a];
          end
          eeprom_pointer_q = eeprom_pointer_q + 16'd1;
        end else if (reg_pointer_q == CmdReg) begin
          w.read_data = page_valid_q ? page_id(int'(page_index_q)) : NoPageId;
        end else if (page_access_ok()) begin
          w.read_data   = page_mem[page_slot()];
          reg_pointer_q = reg_pointer_q + 8'd1;
        end
      end
      FN_HOST_WR, FN_HOST_RD: begin
        wr = (fn == FN_HOST_WR);
        a  = int'(addr);
        if (tgt == TGT_HEADER && a < HEADER_BYTES) begin
          if (wr) header_mem[a] = d;
          else w.read_data = header_mem[a];
        end else if (tgt == TGT_EEPROM && a < EEPROM_BYTES) begin
          if (wr) eeprom_mem[a] = d;
          else w.read_data = eeprom_mem[a];
        end else if (tgt == TGT_PAGE && int'(pg) < NUM_PAGES && a < PAGE_BYTES) begin
          if (wr) page_mem[int'(pg) * PAGE_BYTES + a] = d;
          else w.read_data = page_mem[int'(pg) * PAGE_BYTES + a];
        end
      end
      default: begin
      end
    endcase
    w.page_selected = page_valid_q;
    return w;
  endfunction

  task automatic compare_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_word_t exp_w;
    if (!rst_ni) begin
      page_count_q     = '0;
      page_ids_q       = '0;
      page_sizes_q     = '0;
      eeprom_size_q    = '0;
      on_secondary_q   = 1'b0;
      page_valid_q     = 1'b0;
      page_index_q     = '0;
      reg_pointer_q    = '0;
      pointer_set_q    = 1'b0;
      eeprom_pointer_q = '0;
      high_seen_q      = 1'b0;
      low_seen_q       = 1'b0;
      expected_words.delete();
      pending_count_o  <= 0;
      mismatch_count_o <= mismatches;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_PAGE_COUNT:  page_count_q  = cfg_i.data[2:0];
          CFG_PAGE_IDS:    page_ids_q    = cfg_i.data[31:0];
          CFG_PAGE_SIZES:  page_sizes_q  = cfg_i.data;
          CFG_EEPROM_SIZE: eeprom_size_q = cfg_i.data[13:0];
          default: begin
          end
        endcase
      end
      if (result_i.valid && result_i.ready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("%0t: result word with none expected: expected nothing, actual %0h/%0b/%0b",
                     $time, result_i.read_data, result_i.byte_stored, result_i.page_selected);
          end
        end else begin
          exp_w = expected_words.pop_front();
          compare_field("read_data", exp_w.read_data, result_i.read_data);
          compare_field("byte_stored", 8'(exp_w.byte_stored), 8'(result_i.byte_stored));
          compare_field("page_selected", 8'(exp_w.page_selected), 8'(result_i.page_selected));
        end
      end
      if (item_i.valid && item_i.ready) begin
        expected_words.push_back(predict_word(item_i.func, item_i.data, item_i.host_target,
                                              item_i.host_page, item_i.host_addr));
      end
      pending_count_o  <= expected_words.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

>>> tb/sv/tb_i2c_target_paged_regs_and_eeprom.sv
`timescale 1ns / 1ps
// Testbench top for i2c_target_paged_regs_and_eeprom: clock, reset, configuration phases and
// bus and host event stimulus with random idling; the scoreboard checks every result word.
// Depends on i2ct_pkg, the channel interfaces, the block and i2ct_scoreboard.
module tb_i2c_target_paged_regs_and_eeprom;
  import i2ct_pkg::*;

  localparam int         ClkHalf     = 6;
  localparam int         ResetCycles = 9;
  localparam int         IdlePct     = 7;
  localparam int         StallLimit  = 1000;
  localparam int         DrainCycles = 6;
  localparam int         HoldEvery   = 500;
  localparam int         HoldCycles  = 80;
  localparam int         PhaseItems  = 135;
  localparam int         NumPhases   = 6;
  localparam int         CalmPhase   = 3;
  localparam int         EepLow      = 152;
  localparam int         EepTop      = 16;
  localparam int         PgWin       = 24;
  localparam int         HostAddrMax = 8191;
  localparam logic [2:0] FnUnused    = 3'd7;
  localparam logic [1:0] TgtNone     = 2'd3;

  logic clk_i;
  logic rst_ni;

  i2ct_item_if item_if ();
  i2ct_res_if  result_if ();
  i2ct_cfg_if  cfg_if ();

  int          mismatches;
  int          pending_words;
  bit          calm;
  int          issued;
  int          stall_cycles;
  int          rx_cycle;
  int          hold_left;
  logic [2:0]  cur_count;
  logic [31:0] cur_ids;
  logic [35:0] cur_sizes;
  logic [13:0] cur_eep;

  i2c_target_paged_regs_and_eeprom i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  i2ct_scoreboard i_scoreboard (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (item_if),
    .result_i         (result_if),
    .cfg_i            (cfg_if),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending_words)
  );

  initial begin
    clk_i = 1'b0;
    forever #ClkHalf clk_i = ~clk_i;
  end

  task automatic send_item(input logic [2:0] fn, input logic [7:0] d, input logic [1:0] tgt,
                           input logic [1:0] pg, input logic [12:0] addr);
    if (!calm && $urandom_range(0, 99) < IdlePct) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid       <= 1'b1;
    item_if.func        <= fn;
    item_if.data        <= d;
    item_if.host_target <= tgt;
    item_if.host_page   <= pg;
    item_if.host_addr   <= addr;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    if (fn != FN_STOP && fn != FnUnused) issued++;
  endtask

  task automatic bus_item(input logic [2:0] fn, input logic [7:0] d);
    send_item(fn, d, 2'($urandom), 2'($urandom), 13'($urandom));
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [35:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  function automatic logic [35:0] noise36();
    return {4'($urandom), 32'($urandom)};
  endfunction

  // Offsets that the host has loaded, or offsets outside the store.
  function automatic logic [12:0] loaded_addr(input logic [1:0] tgt);
    logic [12:0] r;
    int          k;
    r = 13'($urandom);
    case (tgt)
      TGT_HEADER: begin
        r = ($urandom_range(0, 99) < 80) ? 13'($urandom_range(0, HEADER_BYTES - 1))
                                         : 13'($urandom_range(HEADER_BYTES, HostAddrMax));
      end
      TGT_EEPROM: begin
        r = ($urandom_range(0, 1) != 0) ? 13'($urandom_range(0, EepLow - 1))
            : 13'($urandom_range(EEPROM_BYTES - EepTop, EEPROM_BYTES - 1));
      end
      TGT_PAGE: begin
        k = $urandom_range(0, 2 * PgWin - 1);
        r = (k < PgWin) ? 13'(k) : 13'(PAGE_BYTES - 2 * PgWin + k);
        if ($urandom_range(0, 99) < 20) r = 13'($urandom_range(PAGE_BYTES, HostAddrMax));
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic wait_drained();
    do @(posedge clk_i); while (pending_words != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic configure(input int p);
    case (p)
      0: begin
        cur_count = 3'd4;
        cur_ids   = 32'hFF22_2211;
        cur_sizes = {9'd3, 9'h1FF, 9'd5, 9'd0};
        cur_eep   = 14'd100;
      end
      1: begin
        cur_count = 3'd7;
        for (int i = 0; i < 4; i++) begin
          cur_ids[8*i +: 8]   = 8'($urandom_range(8'h40, 8'h43));
          cur_sizes[9*i +: 9] = 9'($urandom_range(0, 16));
        end
        cur_eep = 14'(EEPROM_BYTES);
      end
      2: begin
        cur_count = '0;
        cur_ids   = '0;
        cur_sizes = '0;
        cur_eep   = '0;
      end
      3: begin
        cur_count = 3'd4;
        cur_ids   = '1;
        cur_sizes = '1;
        cur_eep   = '1;
      end
      default: begin
        cur_count = 3'($urandom_range(0, 7));
        for (int i = 0; i < 4; i++) begin
          cur_ids[8*i +: 8]   = 8'($urandom_range(8'h40, 8'h47));
          cur_sizes[9*i +: 9] = ($urandom_range(0, 99) < 80) ? 9'($urandom_range(0, 24))
                                                             : 9'($urandom_range(0, 511));
        end
        cur_eep = ($urandom_range(0, 1) != 0) ? 14'($urandom_range(0, EepLow - 12))
                                              : 14'($urandom_range(EEPROM_BYTES, 16383));
      end
    endcase
    item_if.valid <= 1'b0;
    wait_drained();
    write_reg(CFG_PAGE_COUNT, (noise36() & ~36'h7) | 36'(cur_count));
    write_reg(CFG_PAGE_IDS, (noise36() & ~36'hFFFF_FFFF) | 36'(cur_ids));
    write_reg(CFG_PAGE_SIZES, cur_sizes);
    write_reg(CFG_EEPROM_SIZE, (noise36() & ~36'h3FFF) | 36'(cur_eep));
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    logic [7:0]  ptr;
    logic [12:0] a;
    logic [1:0]  tgt;
    logic [2:0]  fn;
    bit          wr;
    int          kind;
    int          n;
    int          lim;
    int          t;
    rst_ni              <= 1'b0;
    item_if.valid       <= 1'b0;
    item_if.func        <= '0;
    item_if.data        <= '0;
    item_if.host_target <= '0;
    item_if.host_page   <= '0;
    item_if.host_addr   <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= '0;
    cfg_if.data         <= '0;
    calm = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The host first loads the whole header, the low and top ends of the EEPROM and both ends of every page.
    for (int i = 0; i < HEADER_BYTES; i++) begin
      send_item(FN_HOST_WR, 8'($urandom), TGT_HEADER, 2'($urandom), 13'(i));
    end
    for (int i = 0; i < EepLow; i++) begin
      send_item(FN_HOST_WR, 8'($urandom), TGT_EEPROM, 2'($urandom), 13'(i));
    end
    for (int i = EEPROM_BYTES - EepTop; i < EEPROM_BYTES; i++) begin
      send_item(FN_HOST_WR, 8'($urandom), TGT_EEPROM, 2'($urandom), 13'(i));
    end
    for (int i = 0; i < NUM_PAGES * 2 * PgWin; i++) begin
      n = i % (2 * PgWin);
      send_item(FN_HOST_WR, 8'($urandom), TGT_PAGE, 2'(i / (2 * PgWin)),
                (n < PgWin) ? 13'(n) : 13'(PAGE_BYTES - 2 * PgWin + n));
    end

    configure(0);
    bus_item(FN_START_PRI, 8'h00);
    bus_item(FN_RECEIVE, CmdReg);
    bus_item(FN_TRANSMIT, 8'hFF);
    bus_item(FN_RECEIVE, 8'h22);
    bus_item(FN_RECEIVE, 8'hFF);
    bus_item(FN_START_PRI, 8'hFF);
    bus_item(FN_RECEIVE, 8'hFF);
    bus_item(FN_START_PRI, 8'h00);
    bus_item(FN_TRANSMIT, 8'h00);
    bus_item(FN_TRANSMIT, 8'h00);
    bus_item(FN_START_PRI, 8'h00);
    bus_item(FN_RECEIVE, CmdReg);
    bus_item(FN_RECEIVE, 8'h99);
    bus_item(FN_TRANSMIT, 8'h00);
    bus_item(FN_STOP, 8'hFF);
    bus_item(FN_START_SEC, 8'h00);
    bus_item(FN_RECEIVE, 8'hFF);
    bus_item(FN_START_SEC, 8'h10);
    bus_item(FN_TRANSMIT, 8'h00);
    bus_item(FN_START_SEC, 8'h00);
    bus_item(FN_RECEIVE, 8'h00);
    bus_item(FN_RECEIVE, 8'h3F);
    bus_item(FN_RECEIVE, 8'h5A);
    bus_item(FN_START_SEC, 8'h00);
    bus_item(FN_RECEIVE, 8'h00);
    bus_item(FN_START_SEC, 8'h3F);
    bus_item(FN_TRANSMIT, 8'h00);
    bus_item(FN_TRANSMIT, 8'h00);
    send_item(FN_HOST_WR, 8'hFF, TgtNone, 2'd3, 13'h1FFF);
    send_item(FN_HOST_RD, 8'h00, TgtNone, 2'd0, 13'h0000);
    send_item(FN_HOST_RD, 8'h00, TGT_HEADER, 2'd0, 13'(HEADER_BYTES));
    send_item(FN_HOST_RD, 8'h00, TGT_PAGE, 2'd3, 13'(PAGE_BYTES));
    bus_item(FnUnused, 8'hFF);

    for (int p = 1; p <= NumPhases; p++) begin
      configure(p);
      calm   = (p == CalmPhase);
      issued = 0;
      lim    = (int'(cur_eep) > EEPROM_BYTES) ? EEPROM_BYTES : int'(cur_eep);
      while (issued < PhaseItems) begin
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
          kind = $urandom_range(0, 99);
          ptr  = (kind < 65) ? 8'($urandom_range(0, 15)) :
                 (kind < 80) ? CmdReg :
                 (kind < 88) ? 8'($urandom_range(240, 255)) : 8'($urandom_range(0, PgWin - 1));
          n = $urandom_range(1, 6);
          bus_item(FN_START_PRI, 8'($urandom));
          bus_item(FN_RECEIVE, ptr);
          if (ptr == CmdReg && $urandom_range(0, 99) < 80) begin
            t = $urandom_range(0, 3);
            bus_item(FN_RECEIVE, ($urandom_range(0, 99) < 80) ? cur_ids[8*t +: 8] : 8'($urandom));
            repeat ($urandom_range(0, 3)) bus_item(FN_RECEIVE, 8'($urandom));
          end else if ($urandom_range(0, 1) != 0) begin
            repeat (n) bus_item(FN_RECEIVE, 8'($urandom));
          end else begin
            bus_item(FN_START_PRI, 8'($urandom));
            repeat (n) bus_item(FN_TRANSMIT, 8'($urandom));
          end
          if ($urandom_range(0, 99) < 80) bus_item(FN_STOP, 8'($urandom));
        end else if (kind < 65) begin
          kind = $urandom_range(0, 99);
          if (kind < 40) begin
            a = 13'($urandom_range(0, 127));
          end else if (kind < 70) begin
            t = lim - 4 + $urandom_range(0, 7);
            if (t < 0) t = 0;
            if (t > EEPROM_BYTES - 1) t = EEPROM_BYTES - 1;
            a = 13'(t);
          end else begin
            a = 13'($urandom_range(EEPROM_BYTES - EepTop, EEPROM_BYTES - 1));
          end
          n = $urandom_range(1, 6);
          bus_item(FN_START_SEC, 8'($urandom));
          bus_item(FN_RECEIVE, {3'($urandom), a[12:8]});
          case ($urandom_range(0, 2))
            0: begin
              bus_item(FN_RECEIVE, a[7:0]);
              repeat (n) bus_item(FN_RECEIVE, 8'($urandom));
            end
            1: begin
              bus_item(FN_START_SEC, a[7:0]);
              repeat (n) bus_item(FN_TRANSMIT, 8'($urandom));
            end
            default: begin
              bus_item(FN_RECEIVE, a[7:0]);
              bus_item(FN_START_SEC, 8'($urandom));
              repeat (n) bus_item(FN_TRANSMIT, 8'($urandom));
            end
          endcase
          if ($urandom_range(0, 99) < 80) bus_item(FN_STOP, 8'($urandom));
        end else if (kind < 80) begin
          tgt = 2'($urandom_range(0, 3));
          wr  = ($urandom_range(0, 1) != 0);
          a   = (wr && $urandom_range(0, 99) < 30) ? 13'($urandom) : loaded_addr(tgt);
          send_item(wr ? FN_HOST_WR : FN_HOST_RD, 8'($urandom), tgt, 2'($urandom), a);
        end else begin
          case ($urandom_range(0, 4))
            0:       fn = FN_START_PRI;
            1:       fn = FN_START_SEC;
            2:       fn = FN_STOP;
            3:       fn = FN_HOST_WR;
            default: fn = FnUnused;
          endcase
          send_item(fn, 8'($urandom), 2'($urandom), 2'($urandom), 13'($urandom));
        end
      end
    end

    calm = 1'b0;
    item_if.valid <= 1'b0;
    wait_drained();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // The periodic hold-off lets the queue fill so that the block has to stall its input.
  initial begin
    rx_cycle  = 0;
    hold_left = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (rx_cycle % HoldEvery == 0 && !calm) hold_left = HoldCycles;
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= calm || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  initial begin
    stall_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule
